### rtl/rfae_pkg.sv
// Shared types and constants for the register file ALU executor.
package rfae_pkg;

  localparam int NUM_REGS_DEF    = 32;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int KIND_W      = 4;
  localparam int IDX_W       = 6;
  localparam int IMM_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int PARITY_BITS = 8;

  localparam logic [KIND_W-1:0] KIND_ADD   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SUB   = 4'd1;
  localparam logic [KIND_W-1:0] KIND_AND   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_XOR   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_OR    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_ADDI  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RSUBI = 4'd6;
  localparam logic [KIND_W-1:0] KIND_ANDI  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_XORI  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_ORI   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_MOVE  = 4'd10;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 4'd11;
  localparam logic [KIND_W-1:0] KIND_SWAP  = 4'd12;
  localparam logic [KIND_W-1:0] KIND_READ  = 4'd13;

  typedef enum logic [2:0] {
    CLS_NOP,
    CLS_ALU,
    CLS_MOVE,
    CLS_LOAD,
    CLS_SWAP,
    CLS_READ
  } cls_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_RSUB,
    ALU_AND,
    ALU_XOR,
    ALU_OR
  } alu_op_t;

  typedef struct packed {
    cls_t             cls;
    alu_op_t          alu_op;
    logic             use_imm;
    logic             err;
    logic [IDX_W-1:0] dst;
    logic [IDX_W-1:0] src_b;
    logic [IDX_W-1:0] src_a;
  } ctl_t;

  typedef struct packed {
    logic sign;
    logic zero;
    logic parity;
  } flags_t;

endpackage

### rtl/rfae_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rfae_queue.sv
// Small FIFO between the decode front end and the execute back end.
module rfae_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign push       = push_valid && push_ready;
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");
`endif

endmodule

### rtl/rfae_front.sv
// Front end: decodes an instruction item, checks its indexes and classifies it.
module rfae_front #(
  parameter int NUM_REGS   = rfae_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = rfae_pkg::DATA_WIDTH_DEF
) (
  input  logic [rfae_pkg::KIND_W-1:0]       kind,
  input  logic [rfae_pkg::IDX_W-1:0]        dest_reg,
  input  logic [rfae_pkg::IDX_W-1:0]        src_reg_b,
  input  logic [rfae_pkg::IDX_W-1:0]        src_reg_a,
  input  logic signed [rfae_pkg::IMM_W-1:0] immediate,
  output rfae_pkg::ctl_t                    ctl,
  output logic [DATA_WIDTH-1:0]             imm_ext
);

  function automatic logic idx_bad(input logic [rfae_pkg::IDX_W-1:0] idx);
    return {1'b0, idx} >= (rfae_pkg::IDX_W + 1)'(NUM_REGS);
  endfunction

  logic bad_d, bad_b, bad_a;

  assign bad_d   = idx_bad(dest_reg);
  assign bad_b   = idx_bad(src_reg_b);
  assign bad_a   = idx_bad(src_reg_a);
  // signed source, so the cast sign-extends (or truncates for narrow data)
  assign imm_ext = DATA_WIDTH'(immediate);

  always_comb begin
    ctl         = '0;
    ctl.cls     = rfae_pkg::CLS_NOP;
    ctl.alu_op  = rfae_pkg::ALU_ADD;
    ctl.dst     = dest_reg;
    ctl.src_b   = src_reg_b;
    ctl.src_a   = src_reg_a;

    unique case (kind) inside
      rfae_pkg::KIND_ADD, rfae_pkg::KIND_SUB, rfae_pkg::KIND_AND,
      rfae_pkg::KIND_XOR, rfae_pkg::KIND_OR: begin
        ctl.cls = rfae_pkg::CLS_ALU;
        ctl.err = bad_d || bad_b || bad_a;
      end
      rfae_pkg::KIND_ADDI, rfae_pkg::KIND_RSUBI, rfae_pkg::KIND_ANDI,
      rfae_pkg::KIND_XORI, rfae_pkg::KIND_ORI: begin
        ctl.cls     = rfae_pkg::CLS_ALU;
        ctl.use_imm = 1'b1;
        ctl.err     = bad_d || bad_b;
      end
      rfae_pkg::KIND_MOVE: begin
        ctl.cls = rfae_pkg::CLS_MOVE;
        ctl.err = bad_d || bad_b;
      end
      rfae_pkg::KIND_LOAD: begin
        ctl.cls = rfae_pkg::CLS_LOAD;
        ctl.err = bad_d;
      end
      rfae_pkg::KIND_SWAP: begin
        ctl.cls = rfae_pkg::CLS_SWAP;
        ctl.err = bad_d || bad_b;
      end
      rfae_pkg::KIND_READ: begin
        ctl.cls = rfae_pkg::CLS_READ;
        ctl.err = bad_b;
      end
      default: begin
        ctl.cls = rfae_pkg::CLS_NOP;
      end
    endcase

    case (kind) inside
      rfae_pkg::KIND_SUB:                      ctl.alu_op = rfae_pkg::ALU_SUB;
      rfae_pkg::KIND_RSUBI:                    ctl.alu_op = rfae_pkg::ALU_RSUB;
      rfae_pkg::KIND_AND, rfae_pkg::KIND_ANDI: ctl.alu_op = rfae_pkg::ALU_AND;
      rfae_pkg::KIND_XOR, rfae_pkg::KIND_XORI: ctl.alu_op = rfae_pkg::ALU_XOR;
      rfae_pkg::KIND_OR, rfae_pkg::KIND_ORI:   ctl.alu_op = rfae_pkg::ALU_OR;
      default:                                 ctl.alu_op = rfae_pkg::ALU_ADD;
    endcase

    // a failed index check turns the item into a no-op that only reports
    if (ctl.err) begin
      ctl.cls = rfae_pkg::CLS_NOP;
    end
  end

endmodule

### rtl/rfae_back.sv
// Back end: register file read, ALU, write back, flags and the result register.
module rfae_back #(
  parameter int NUM_REGS   = rfae_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = rfae_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  rfae_pkg::ctl_t                      q_ctl,
  input  logic [DATA_WIDTH-1:0]               q_imm,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rfae_pkg::VALUE_W-1:0] out_value,
  output logic                                out_parity_flag,
  output logic                                out_zero_flag,
  output logic                                out_sign_flag,
  output logic                                out_index_error
);

  localparam int AW = $clog2(NUM_REGS);

  function automatic logic [DATA_WIDTH-1:0] fwd(
    input logic [AW-1:0]         addr,
    input logic [DATA_WIDTH-1:0] q,
    input logic                  vb,
    input logic                  bvld,
    input logic [AW-1:0]         baddr,
    input logic [DATA_WIDTH-1:0] bdata
  );
    logic [DATA_WIDTH-1:0] v;
    if (bvld && (baddr == addr)) begin
      v = bdata;
    end else if (vb) begin
      v = q;
    end else begin
      v = DATA_WIDTH'(addr);  // never written: reset contents
    end
    return v;
  endfunction

  // execute stage
  logic                  ex_vld_r, ex_vld_nxt;
  rfae_pkg::ctl_t        ex_ctl_r;
  logic [DATA_WIDTH-1:0] ex_imm_r;
  logic                  phase_r, phase_nxt;
  logic                  vb0_r, vb1_r;

  // write that landed on the same edge as the stage's read
  logic                  byp_vld_r;
  logic [AW-1:0]         byp_addr_r;
  logic [DATA_WIDTH-1:0] byp_data_r;

  logic [NUM_REGS-1:0]   wrt_r, wrt_nxt;
  rfae_pkg::flags_t      flags_r, flags_nxt, alu_flags;

  logic                  out_vld_r, out_vld_nxt;
  logic [DATA_WIDTH-1:0] out_value_r;
  rfae_pkg::flags_t      out_flags_r;
  logic                  out_err_r;

  logic                  pop, done, swap_first, out_free;
  logic [AW-1:0]         rd_addr0, rd_addr1, ex_addr0, ex_addr1, ex_dst;
  logic [DATA_WIDTH-1:0] ram_q0, ram_q1, opx, opy, opnd2, alu_res, res_value;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  assign rd_addr0 = q_ctl.src_b[AW-1:0];
  assign rd_addr1 = (q_ctl.cls == rfae_pkg::CLS_SWAP) ? q_ctl.dst[AW-1:0]
                                                      : q_ctl.src_a[AW-1:0];

  rfae_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_ram0 (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (pop),
    .rd_addr (rd_addr0),
    .rd_data (ram_q0)
  );

  rfae_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_ram1 (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (pop),
    .rd_addr (rd_addr1),
    .rd_data (ram_q1)
  );

  assign ex_addr0 = ex_ctl_r.src_b[AW-1:0];
  assign ex_addr1 = (ex_ctl_r.cls == rfae_pkg::CLS_SWAP) ? ex_ctl_r.dst[AW-1:0]
                                                         : ex_ctl_r.src_a[AW-1:0];
  assign ex_dst   = ex_ctl_r.dst[AW-1:0];

  assign opx   = fwd(ex_addr0, ram_q0, vb0_r, byp_vld_r, byp_addr_r, byp_data_r);
  assign opy   = fwd(ex_addr1, ram_q1, vb1_r, byp_vld_r, byp_addr_r, byp_data_r);
  assign opnd2 = ex_ctl_r.use_imm ? ex_imm_r : opy;

  always_comb begin
    case (ex_ctl_r.alu_op)
      rfae_pkg::ALU_ADD:  alu_res = opx + opnd2;
      rfae_pkg::ALU_SUB:  alu_res = opx - opnd2;
      rfae_pkg::ALU_RSUB: alu_res = opnd2 - opx;
      rfae_pkg::ALU_AND:  alu_res = opx & opnd2;
      rfae_pkg::ALU_XOR:  alu_res = opx ^ opnd2;
      rfae_pkg::ALU_OR:   alu_res = opx | opnd2;
      default:            alu_res = opx + opnd2;
    endcase
  end

  always_comb begin
    alu_flags.parity = ^alu_res[rfae_pkg::PARITY_BITS-1:0];
    alu_flags.zero   = (alu_res == '0);
    alu_flags.sign   = alu_res[DATA_WIDTH-1];
  end

  always_comb begin
    case (ex_ctl_r.cls)
      rfae_pkg::CLS_ALU:  res_value = alu_res;
      rfae_pkg::CLS_MOVE: res_value = opx;
      rfae_pkg::CLS_LOAD: res_value = ex_imm_r;
      rfae_pkg::CLS_SWAP: res_value = opx;
      rfae_pkg::CLS_READ: res_value = opx;
      default:            res_value = '0;
    endcase
  end

  // swap takes two passes through the single write port: R[d] first, then R[b]
  assign swap_first = ex_vld_r && (ex_ctl_r.cls == rfae_pkg::CLS_SWAP) && !phase_r;
  assign out_free   = !out_vld_r || out_ready;
  assign done       = ex_vld_r && !swap_first && out_free;
  assign pop        = q_valid && (!ex_vld_r || done);
  assign q_pop      = pop;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ex_dst;
    wr_data = res_value;
    if (swap_first) begin
      wr_en   = 1'b1;
      wr_data = opx;
    end else if (done) begin
      case (ex_ctl_r.cls)
        rfae_pkg::CLS_ALU, rfae_pkg::CLS_MOVE, rfae_pkg::CLS_LOAD: begin
          wr_en = 1'b1;
        end
        rfae_pkg::CLS_SWAP: begin
          wr_en   = 1'b1;
          wr_addr = ex_addr0;
          wr_data = opy;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    wrt_nxt = wrt_r;
    if (wr_en) begin
      wrt_nxt[wr_addr] = 1'b1;
    end
    flags_nxt = (done && (ex_ctl_r.cls == rfae_pkg::CLS_ALU)) ? alu_flags : flags_r;
    ex_vld_nxt = pop ? 1'b1 : (done ? 1'b0 : ex_vld_r);
    phase_nxt  = swap_first ? 1'b1 : (done ? 1'b0 : phase_r);
    out_vld_nxt = done ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r  <= 1'b0;
      phase_r   <= 1'b0;
      byp_vld_r <= 1'b0;
      wrt_r     <= '0;
      flags_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      ex_vld_r  <= ex_vld_nxt;
      phase_r   <= phase_nxt;
      wrt_r     <= wrt_nxt;
      flags_r   <= flags_nxt;
      out_vld_r <= out_vld_nxt;
      if (pop) begin
        byp_vld_r <= wr_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ex_ctl_r   <= q_ctl;
      ex_imm_r   <= q_imm;
      vb0_r      <= wrt_r[rd_addr0];
      vb1_r      <= wrt_r[rd_addr1];
      byp_addr_r <= wr_addr;
      byp_data_r <= wr_data;
    end
    if (done) begin
      out_value_r <= res_value;
      out_flags_r <= flags_nxt;
      out_err_r   <= ex_ctl_r.err;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_value       = rfae_pkg::VALUE_W'(out_value_r);
  assign out_parity_flag = out_flags_r.parity;
  assign out_zero_flag   = out_flags_r.zero;
  assign out_sign_flag   = out_flags_r.sign;
  assign out_index_error = out_err_r;

`ifndef SYNTHESIS
  a_phase_swap: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> ex_vld_r && (ex_ctl_r.cls == rfae_pkg::CLS_SWAP))
    else $error("swap second pass without a swap in execute");
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ex_vld_r && ex_ctl_r.err |-> !wr_en)
    else $error("register write from an item with an index error");
  a_swap_two_pass: assert property (@(posedge clk) disable iff (!rst_n)
    done && (ex_ctl_r.cls == rfae_pkg::CLS_SWAP) |-> phase_r)
    else $error("swap finished without its first write");
  a_bypass_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> byp_vld_r == $past(wr_en))
    else $error("bypass missed the write on the read edge");
`endif

endmodule

### rtl/register_file_alu_executor_top.sv
// Top level of the register file ALU executor.
// One instruction item per cycle is accepted and one result item per cycle is
// delivered while out_ready is high and no swap is in execute; a swap needs a
// second pass in execute as the register file has a single write port. An item
// goes from decode into the queue, to the register file read (RAM with
// registered read data, duplicated for two read ports), then ALU, write back
// and the result register. A write in flight is forwarded to the following
// item. After reset every register reads as its own index through per-entry
// written bits, so no clearing pass is needed and items are taken at once.
module register_file_alu_executor_top #(
  parameter int NUM_REGS    = rfae_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH  = rfae_pkg::DATA_WIDTH_DEF,
  parameter int QUEUE_DEPTH = rfae_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rfae_pkg::KIND_W-1:0]         in_kind,
  input  logic [rfae_pkg::IDX_W-1:0]          in_dest_reg,
  input  logic [rfae_pkg::IDX_W-1:0]          in_src_reg_b,
  input  logic [rfae_pkg::IDX_W-1:0]          in_src_reg_a,
  input  logic signed [rfae_pkg::IMM_W-1:0]   in_immediate,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rfae_pkg::VALUE_W-1:0] out_value,
  output logic                                out_parity_flag,
  output logic                                out_zero_flag,
  output logic                                out_sign_flag,
  output logic                                out_index_error
);

  localparam int CTL_W = $bits(rfae_pkg::ctl_t);
  localparam int Q_W   = CTL_W + DATA_WIDTH;

  rfae_pkg::ctl_t        dec_ctl, q_ctl;
  logic [DATA_WIDTH-1:0] dec_imm, q_imm;
  logic [Q_W-1:0]        q_data;
  logic                  q_valid, q_pop;

  rfae_front #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_front (
    .kind      (in_kind),
    .dest_reg  (in_dest_reg),
    .src_reg_b (in_src_reg_b),
    .src_reg_a (in_src_reg_a),
    .immediate (in_immediate),
    .ctl       (dec_ctl),
    .imm_ext   (dec_imm)
  );

  rfae_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  ({dec_ctl, dec_imm}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign q_ctl = rfae_pkg::ctl_t'(q_data[Q_W-1:DATA_WIDTH]);
  assign q_imm = q_data[DATA_WIDTH-1:0];

  rfae_back #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ctl           (q_ctl),
    .q_imm           (q_imm),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_parity_flag (out_parity_flag),
    .out_zero_flag   (out_zero_flag),
    .out_sign_flag   (out_sign_flag),
    .out_index_error (out_index_error)
  );

endmodule
